/* rtl/bae_pkg.sv */
// Shared types and constants of the bounded array engine.
package bae_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW    = (CW > 5) ? CW : 5;

    typedef enum logic [2:0] {
        REQ_APPEND,
        REQ_REMOVE,
        REQ_ROT_L1,
        REQ_ROT_R1,
        REQ_ROT_BY,
        REQ_SEARCH,
        REQ_DUMP,
        REQ_NONE
    } t_req;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_EXEC,
        S_MOD,
        S_LOADH,
        S_HOLD,
        S_STEP,
        S_MOVE,
        S_SRD,
        S_SCMP,
        S_DRD,
        S_DOUT,
        S_FIN
    } t_state;

    typedef enum logic {
        RD_I,
        RD_D
    } t_rdsel;

    typedef struct packed {
        logic   cap;
        logic   exec;
        logic   mod_step;
        logic   rd_en;
        t_rdsel rd_sel;
        logic   ld_held;
        logic   mv_write;
        logic   close_write;
        logic   inc_i;
        logic   scan_cmp;
        logic   out_single;
        logic   out_dump;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic n_zero;
        logic k_ge_n;
        logic k_zero;
        logic d_eq_i;
        logic rot_done;
        logic scan_end;
        logic dump_last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/bounded_array_engine.sv */
// Top level of the bounded array engine.
//
//   channel  | direction | handshake          | fields
//   request  | in        | i_valid / o_stall  | i_req_type, i_value, i_amount
//   result   | out       | o_valid / i_stall  | o_status, o_found, o_count, o_data, o_last
//
// One request is served at a time; the word store is a RAM with one read and one write port.
// Append, remove and idle codes pass through dispatch and execute to the finish state and its result beat.
// A rotation first reduces the amount by repeated subtraction of the fill count, then moves
// each gcd cycle word by word, each word read and then written, all bound by the single RAM read port.
// A search reads and compares each stored word in turn; a dump reads each word, then loads it as a result beat.
// Reset clears the fill count and the result valid flag; no clearing pass is needed.
// A stalled result beat holds the engine before it loads the next beat.
module bounded_array_engine (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [2:0]             i_req_type,
    input  logic signed [31:0]     i_value,
    input  logic [4:0]             i_amount,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic                   o_found,
    output logic [bae_pkg::CW-1:0] o_count,
    output logic signed [31:0]     o_data,
    output logic                   o_last
);
    import bae_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bae_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bae_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .i_amount   (i_amount),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_found    (o_found),
        .o_count    (o_count),
        .o_data     (o_data),
        .o_last     (o_last)
    );
endmodule

/* rtl/bae_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module bae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/bae_ctrl.sv */
// Request sequencer of the bounded array engine.
module bae_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bae_pkg::t_sts i_sts,
    output bae_pkg::t_cmd o_cmd
);
    import bae_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.req)
                    REQ_ROT_L1, REQ_ROT_R1, REQ_ROT_BY: n_state = S_MOD;
                    REQ_SEARCH: n_state = S_SRD;
                    REQ_DUMP:   n_state = i_sts.n_zero ? S_FIN : S_DRD;
                    default:    n_state = S_EXEC;
                endcase
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_FIN;
            end
            S_MOD: begin
                if (i_sts.n_zero) begin
                    n_state = S_FIN;
                end else if (i_sts.k_ge_n) begin
                    o_cmd.mod_step = 1'b1;
                end else if (i_sts.k_zero) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_LOADH;
                end
            end
            S_LOADH: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_I;
                n_state      = S_HOLD;
            end
            S_HOLD: begin
                o_cmd.ld_held = 1'b1;
                n_state       = S_STEP;
            end
            S_STEP: begin
                if (i_sts.d_eq_i) begin
                    o_cmd.close_write = 1'b1;
                    n_state = i_sts.rot_done ? S_FIN : S_LOADH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_D;
                    n_state      = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.mv_write = 1'b1;
                n_state        = S_STEP;
            end
            S_SRD: begin
                if (i_sts.scan_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_I;
                    o_cmd.inc_i  = 1'b1;
                    n_state      = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = S_SRD;
            end
            S_DRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_I;
                n_state      = S_DOUT;
            end
            S_DOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_dump = 1'b1;
                    o_cmd.inc_i    = 1'b1;
                    n_state = i_sts.dump_last ? S_IDLE : S_DRD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_single = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
endmodule

/* rtl/bae_dp.sv */
// Datapath of the bounded array engine: word store, count, indexes and result register.
module bae_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bae_pkg::t_cmd        i_cmd,
    output bae_pkg::t_sts        o_sts,
    input  logic [2:0]           i_req_type,
    input  logic signed [31:0]   i_value,
    input  logic [4:0]           i_amount,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_status,
    output logic                 o_found,
    output logic [bae_pkg::CW-1:0] o_count,
    output logic signed [31:0]   o_data,
    output logic                 o_last
);
    import bae_pkg::*;

    t_req             r_req;
    logic [31:0]      r_val;
    logic [KW-1:0]    r_k;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_i;
    logic [AW-1:0]    r_j;
    logic [CW-1:0]    r_moved;
    logic [31:0]      r_held;
    logic             r_found;
    t_status          r_st;
    logic             r_o_valid;
    t_status          r_o_status;
    logic             r_o_found;
    logic [CW-1:0]    r_o_count;
    logic [31:0]      r_o_data;
    logic             r_o_last;

    logic [31:0]      rdata;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [31:0]      wdata;
    logic [AW-1:0]    raddr;
    logic [KW:0]      sum;
    logic [KW:0]      n_ext;
    logic [AW-1:0]    d;
    logic             full;
    logic             out_free;

    assign n_ext    = (KW + 1)'(r_cnt);
    assign sum      = (KW + 1)'(r_j) + {1'b0, r_k};
    assign d        = (sum >= n_ext) ? AW'(sum - n_ext) : AW'(sum);
    assign full     = (r_cnt == CW'(DEPTH));
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        we    = 1'b0;
        waddr = r_j;
        wdata = rdata;
        if (i_cmd.exec && r_req == REQ_APPEND && !full) begin
            we    = 1'b1;
            waddr = r_cnt[AW-1:0];
            wdata = r_val;
        end else if (i_cmd.mv_write) begin
            we = 1'b1;
        end else if (i_cmd.close_write) begin
            we    = 1'b1;
            wdata = r_held;
        end
    end

    assign raddr = (i_cmd.rd_sel == RD_D) ? d : r_i[AW-1:0];

    bae_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.exec) begin
            if (r_req == REQ_APPEND && !full) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (r_req == REQ_REMOVE && r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req   <= t_req'(i_req_type);
            r_val   <= i_value;
            r_i     <= '0;
            r_j     <= '0;
            r_moved <= '0;
            r_found <= 1'b0;
            r_st    <= ST_OK;
            case (t_req'(i_req_type))
                REQ_ROT_L1: r_k <= KW'(1);
                REQ_ROT_R1: r_k <= KW'(r_cnt - CW'(1));
                default:    r_k <= KW'(i_amount);
            endcase
        end
        if (i_cmd.exec) begin
            if (r_req == REQ_APPEND && full) begin
                r_st <= ST_FULL;
            end else if (r_req == REQ_REMOVE && r_cnt == '0) begin
                r_st <= ST_EMPTY;
            end
        end
        if (i_cmd.mod_step) begin
            r_k <= r_k - KW'(r_cnt);
        end
        if (i_cmd.ld_held) begin
            r_held <= rdata;
            r_j    <= r_i[AW-1:0];
        end
        if (i_cmd.mv_write) begin
            r_j     <= d;
            r_moved <= r_moved + CW'(1);
        end
        if (i_cmd.close_write) begin
            r_moved <= r_moved + CW'(1);
            r_i     <= r_i + CW'(1);
        end
        if (i_cmd.inc_i) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.scan_cmp && rdata == r_val) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_single || i_cmd.out_dump) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_single) begin
            r_o_status <= r_st;
            r_o_found  <= r_found;
            r_o_count  <= r_cnt;
            r_o_data   <= '0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.out_dump) begin
            r_o_status <= ST_OK;
            r_o_found  <= 1'b0;
            r_o_count  <= r_cnt;
            r_o_data   <= rdata;
            r_o_last   <= (r_i + CW'(1) == r_cnt);
        end
    end

    assign o_sts.req       = r_req;
    assign o_sts.n_zero    = (r_cnt == '0);
    assign o_sts.k_ge_n    = ((KW + 1)'(r_k) >= n_ext);
    assign o_sts.k_zero    = (r_k == '0);
    assign o_sts.d_eq_i    = (d == r_i[AW-1:0]);
    assign o_sts.rot_done  = (r_moved + CW'(1) == r_cnt);
    assign o_sts.scan_end  = (r_i == r_cnt);
    assign o_sts.dump_last = (r_i + CW'(1) == r_cnt);
    assign o_sts.out_free  = out_free;

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_found  = r_o_found;
    assign o_count  = r_o_count;
    assign o_data   = r_o_data;
    assign o_last   = r_o_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("Fill count exceeds the depth.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |-> !(i_cmd.out_single || i_cmd.out_dump))
        else $error("Result register loaded while its beat is stalled.");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_req == REQ_APPEND && !full) |=> r_cnt == $past(r_cnt) + CW'(1))
        else $error("Append did not grow the fill count.");

    a_rot_within: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mv_write || i_cmd.close_write) |-> (CW'(r_j) < r_cnt))
        else $error("Rotation writes outside the stored words.");
endmodule

/* tb/testbench.sv */
// Testbench of the bounded array engine: a scoreboard predicts every result beat and checks it.
module testbench;
    import bae_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [5:0]  count;
        logic [31:0] data;
        logic        last;
    } t_beat;

    class array_scoreboard;
        logic [31:0] store [DEPTH];
        int          fill;
        t_beat       pending [$];
        int          mismatches;

        function void reset_state();
            fill = 0;
            pending.delete();
            mismatches = 0;
        endfunction

        function void rotate_left(int k);
            logic [31:0] tmp [DEPTH];
            if (fill == 0) return;
            k = k % fill;
            for (int i = 0; i < fill; i++) tmp[i] = store[(i + k) % fill];
            for (int i = 0; i < fill; i++) store[i] = tmp[i];
        endfunction

        function void note_request(t_req req, logic [31:0] val, logic [4:0] amt);
            t_beat b;
            b = '{status: ST_OK, found: 1'b0, count: 6'd0, data: 32'd0, last: 1'b1};
            case (req)
                REQ_APPEND: begin
                    if (fill >= DEPTH) begin
                        b.status = ST_FULL;
                    end else begin
                        store[fill] = val;
                        fill++;
                    end
                end
                REQ_REMOVE: begin
                    if (fill == 0) b.status = ST_EMPTY;
                    else fill--;
                end
                REQ_ROT_L1: rotate_left(1);
                REQ_ROT_R1: if (fill > 0) rotate_left(fill - 1);
                REQ_ROT_BY: rotate_left(amt);
                REQ_SEARCH: begin
                    for (int i = 0; i < fill; i++) if (store[i] == val) b.found = 1'b1;
                end
                REQ_DUMP: begin
                    if (fill > 0) begin
                        for (int i = 0; i < fill; i++) begin
                            b.count = 6'(fill);
                            b.data = store[i];
                            b.last = (i == fill - 1);
                            pending.insert(pending.size(), b);
                        end
                        return;
                    end
                end
                default: ;
            endcase
            b.count = 6'(fill);
            pending.insert(pending.size(), b);
        endfunction

        function void check_result(t_beat got);
            t_beat want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected st=%0d f=%0d c=%0d d=%h l=%0d, ",
                              "got st=%0d f=%0d c=%0d d=%h l=%0d"},
                        want.status, want.found, want.count, want.data, want.last,
                        got.status, got.found, got.count, got.data, got.last);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_req_type = '0;
    logic signed [31:0] i_value = '0;
    logic [4:0]         i_amount = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic               o_found;
    logic [CW-1:0]      o_count;
    logic signed [31:0] o_data;
    logic               o_last;

    array_scoreboard sb;
    bit   idle_on = 1'b1;
    bit   hold_rx = 1'b0;
    int   cycles = 0;
    int   model_fill = 0;
    logic [31:0] known [$];

    bounded_array_engine dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_status, o_found, 6'(o_count), o_data, o_last});
    end

    initial begin : receiver
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 5);
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send(t_req req, logic [31:0] val, logic [4:0] amt);
        @(posedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) repeat ($urandom_range(1, 5)) @(posedge i_clk);
        i_valid <= 1'b1;
        i_req_type <= req;
        i_value <= val;
        i_amount <= amt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(req, val, amt);
        if (req == REQ_APPEND && model_fill < DEPTH) begin
            model_fill++;
            known.insert(known.size(), val);
        end
        if (req == REQ_REMOVE && model_fill > 0) model_fill--;
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        v = $urandom;
        if (r < 30) send(REQ_APPEND, v, 5'($urandom));
        else if (r < 42) send(REQ_REMOVE, v, 5'($urandom));
        else if (r < 52) send(REQ_ROT_L1, v, 5'($urandom));
        else if (r < 60) send(REQ_ROT_R1, v, 5'($urandom));
        else if (r < 75) send(REQ_ROT_BY, v, 5'($urandom));
        else if (r < 88) begin
            if (known.size() > 0 && $urandom_range(0, 1))
                v = known[$urandom_range(0, known.size() - 1)];
            send(REQ_SEARCH, v, 5'($urandom));
        end else if (r < 97) send(REQ_DUMP, v, 5'($urandom));
        else send(REQ_NONE, v, 5'($urandom));
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(REQ_REMOVE, 32'd0, 5'd0);
        send(REQ_ROT_L1, 32'd0, 5'd0);
        send(REQ_ROT_R1, 32'd0, 5'd0);
        send(REQ_ROT_BY, 32'd0, 5'd31);
        send(REQ_SEARCH, 32'h8000_0000, 5'd0);
        send(REQ_DUMP, 32'd0, 5'd0);
        send(REQ_NONE, 32'hFFFF_FFFF, 5'd31);
        send(REQ_APPEND, 32'h8000_0000, 5'd0);
        send(REQ_APPEND, 32'h7FFF_FFFF, 5'd0);
        send(REQ_APPEND, 32'hFFFF_FFFF, 5'd0);
        send(REQ_SEARCH, 32'h7FFF_FFFF, 5'd0);
        send(REQ_ROT_BY, 32'd0, 5'd3);
        send(REQ_ROT_BY, 32'd0, 5'd31);
        send(REQ_ROT_R1, 32'd0, 5'd0);
        send(REQ_DUMP, 32'd0, 5'd0);

        // Fill to the top, with the receiver held off at first, then overflow.
        hold_rx = 1'b1;
        while (model_fill < DEPTH) send(REQ_APPEND, $urandom, 5'd0);
        send(REQ_APPEND, 32'h1234_5678, 5'd0);
        drain();
        send(REQ_ROT_BY, 32'd0, 5'd12);
        send(REQ_ROT_BY, 32'd0, 5'd31);
        send(REQ_DUMP, 32'd0, 5'd0);
        send(REQ_SEARCH, 32'h1234_5678, 5'd0);

        for (int n = 0; n < 70; n++) begin
            if (n == 50) begin
                drain();
                idle_on = 1'b0;
            end
            random_item();
        end
        while (model_fill > 0) send(REQ_REMOVE, 32'd0, 5'd0);
        send(REQ_REMOVE, 32'd0, 5'd0);

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/bae_pkg.sv
rtl/bae_ram.sv
rtl/bae_ctrl.sv
rtl/bae_dp.sv
rtl/bounded_array_engine.sv
tb/testbench.sv
